>>> sv/moon_phase_disc_spans_unit_macros.svh
// assertion macros for the moon phase disc span unit
`ifndef MOON_PHASE_DISC_SPANS_UNIT_MACROS_SVH
`define MOON_PHASE_DISC_SPANS_UNIT_MACROS_SVH
`ifndef SYNTH
`define MPD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MPD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define MPD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> sv/mpd_pkg.sv
// shared types, constants and cosine table for the moon phase disc span unit
package mpd_pkg;

    localparam int unsigned HalfMonth = 3780;
    localparam int unsigned CosSteps  = 64;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic row_start;
        logic sqrt_step;
        logic mul_step;
        logic finish;
        logic row_next;
    } mpd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sqrt_done;
        logic last_row;
    } mpd_stat_t;

    // quarter wave cosine, q1.14
    function automatic logic [14:0] cos_quarter(input logic [5:0] idx);
        logic [14:0] v;
        begin
            unique case (idx)
                6'd0: v = 15'd16384;  6'd1: v = 15'd16364;  6'd2: v = 15'd16305;
                6'd3: v = 15'd16207;  6'd4: v = 15'd16069;  6'd5: v = 15'd15893;
                6'd6: v = 15'd15679;  6'd7: v = 15'd15426;  6'd8: v = 15'd15137;
                6'd9: v = 15'd14811;  6'd10: v = 15'd14449; 6'd11: v = 15'd14053;
                6'd12: v = 15'd13623; 6'd13: v = 15'd13160; 6'd14: v = 15'd12665;
                6'd15: v = 15'd12140; 6'd16: v = 15'd11585; 6'd17: v = 15'd11003;
                6'd18: v = 15'd10394; 6'd19: v = 15'd9760;  6'd20: v = 15'd9102;
                6'd21: v = 15'd8423;  6'd22: v = 15'd7723;  6'd23: v = 15'd7005;
                6'd24: v = 15'd6270;  6'd25: v = 15'd5520;  6'd26: v = 15'd4756;
                6'd27: v = 15'd3981;  6'd28: v = 15'd3196;  6'd29: v = 15'd2404;
                6'd30: v = 15'd1606;  6'd31: v = 15'd804;
                default: v = 15'd0;
            endcase
            return v;
        end
    endfunction

    // signed cosine over the half wave, index saturated at pi
    function automatic logic signed [15:0] cos_q14(input logic [6:0] idx);
        logic [6:0] i;
        logic [6:0] m;
        logic signed [15:0] v;
        begin
            i = (idx > 7'(CosSteps)) ? 7'(CosSteps) : idx;
            m = 7'(CosSteps) - i;
            if (i <= 7'd32) begin
                v = $signed({1'b0, cos_quarter(i[5:0])});
            end else begin
                v = -$signed({1'b0, cos_quarter(m[5:0])});
            end
            return v;
        end
    endfunction

endpackage

>>> sv/moon_phase_disc_spans_unit.sv
// top level of the moon phase disc span unit
// One word in (centre, radius, moon age) gives 2*radius+1 span words, top row first,
// the bottom one marked by last_row. Each row runs a restoring square root that
// settles one result bit per cycle, then a multiply by the cosine and a clamp stage,
// then waits for m_ready. A new word is taken only after the last row of the
// previous one has been delivered.
module moon_phase_disc_spans_unit #(
    parameter int unsigned MAX_RADIUS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_center_x,
    input  logic [9:0]  s_center_y,
    input  logic [4:0]  s_radius,
    input  logic [12:0] s_moon_age,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_row_y,
    output logic [11:0] m_span_left,
    output logic [11:0] m_span_right,
    output logic        m_span_empty,
    output logic        m_last_row
);

    mpd_pkg::mpd_cmd_t  cmd;
    mpd_pkg::mpd_stat_t stat;

    // sequencer
    mpd_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .cmd, .stat
    );

    // arithmetic
    mpd_datapath #(.MaxRadius(MAX_RADIUS)) u_dp (
        .aclk, .aresetn, .s_center_x, .s_center_y, .s_radius, .s_moon_age,
        .cmd, .stat, .m_row_y, .m_span_left, .m_span_right, .m_span_empty,
        .m_last_row
    );

endmodule

>>> sv/mpd_ctrl.sv
// controller state machine for the moon phase disc span unit
module mpd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output mpd_pkg::mpd_cmd_t cmd,
    input  mpd_pkg::mpd_stat_t stat
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ROW  = 6'b000010,
        ST_SQRT = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_ROW;
            ST_ROW:  state_next = ST_SQRT;
            ST_SQRT: if (stat.sqrt_done) state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) state_next = stat.last_row ? ST_IDLE : ST_ROW;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    // commands
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign cmd.load      = s_ready && s_valid;
    assign cmd.row_start = (state_reg == ST_ROW);
    assign cmd.sqrt_step = (state_reg == ST_SQRT);
    assign cmd.mul_step  = (state_reg == ST_MUL);
    assign cmd.finish    = (state_reg == ST_FIN);
    assign cmd.row_next  = m_valid && m_ready && !stat.last_row;

    `include "moon_phase_disc_spans_unit_macros.svh"
    `MPD_ASSERT_IMPL(a_no_both, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `MPD_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && stat.last_row, s_ready)
    `MPD_ASSERT_NEXT(a_load_row, aclk, aresetn, cmd.load, cmd.row_start)

endmodule

>>> sv/mpd_datapath.sv
// datapath: held item, row counter, bit serial square root and terminator
module mpd_datapath #(
    parameter int unsigned MaxRadius = 31
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [9:0]         s_center_x,
    input  logic [9:0]         s_center_y,
    input  logic [4:0]         s_radius,
    input  logic [12:0]        s_moon_age,
    input  mpd_pkg::mpd_cmd_t  cmd,
    output mpd_pkg::mpd_stat_t stat,
    output logic [11:0]        m_row_y,
    output logic [11:0]        m_span_left,
    output logic [11:0]        m_span_right,
    output logic               m_span_empty,
    output logic               m_last_row
);

    logic [9:0]  cx_reg;
    logic [9:0]  cy_reg;
    logic [4:0]  r_reg;
    logic        waxing_reg;
    logic signed [15:0] cos_reg;
    logic [5:0]  off_reg;
    logic [19:0] rem_reg;
    logic [12:0] res_reg;
    logic [3:0]  step_reg;
    logic signed [31:0] prod_reg;
    logic signed [13:0] xl_reg, xr_reg;
    logic [11:0] row_reg, left_reg, right_reg;
    logic        empty_reg, last_reg;

    // item decode
    logic [4:0]  r_sat;
    logic        wax;
    logic [12:0] phase;
    logic [20:0] idx_num;
    logic [34:0] idx_prod;
    logic [6:0]  idx;
    assign r_sat   = (s_radius > 5'(MaxRadius)) ? 5'(MaxRadius) : s_radius;
    assign wax     = s_moon_age < 13'(mpd_pkg::HalfMonth);
    assign phase   = wax ? s_moon_age : s_moon_age - 13'(mpd_pkg::HalfMonth);
    assign idx_num = 21'({phase, 7'b0}) + 21'(mpd_pkg::HalfMonth);
    // rounded table index: the divisor is 8 * 945, the 945 part by reciprocal
    // multiplication, (m * 71015) >> 26 is exact for m below 2^17
    assign idx_prod = 35'(idx_num[20:3]) * 35'd71015;
    assign idx      = idx_prod[32:26];

    // row geometry
    logic signed [6:0] dy;
    logic signed [13:0] dy_sq;
    logic [9:0] dy2;
    logic [9:0] d2;
    assign dy    = $signed({1'b0, off_reg}) - $signed({2'b0, r_reg});
    assign dy_sq = 14'(dy) * 14'(dy);
    assign dy2   = dy_sq[9:0];
    assign d2    = 10'(r_reg * r_reg) - dy2;

    // one sqrt step: two radicand bits per cycle, bit position from step
    logic [25:0] v_full;
    logic [1:0]  pair;
    logic [21:0] trial;
    logic [21:0] rem_sh;
    assign v_full = {d2, 16'b0};
    assign pair   = v_full[{step_reg, 1'b1} -: 2];
    assign rem_sh = {rem_reg, pair};
    assign trial  = {7'b0, res_reg, 2'b01};

    // terminator from product
    logic signed [33:0] total;
    logic [33:0] mag;
    logic signed [13:0] term, left, right;
    assign total = $signed({12'b0, cx_reg, 12'b0}) * 34'sd1024 + 34'(prod_reg);
    assign mag   = total[33] ? 34'(-total) : 34'(total);
    assign term  = total[33] ? -$signed(14'(mag >> 22)) : $signed(14'(mag >> 22));
    always_comb begin
        left  = waxing_reg ? term : xl_reg;
        right = waxing_reg ? xr_reg : term;
        if (left < xl_reg) left = xl_reg;
        if (right > xr_reg) right = xr_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg     <= s_center_x;
            cy_reg     <= s_center_y;
            r_reg      <= r_sat;
            waxing_reg <= wax;
            cos_reg    <= mpd_pkg::cos_q14(idx);
            off_reg    <= '0;
        end
        if (cmd.row_start) begin
            rem_reg  <= '0;
            res_reg  <= '0;
            step_reg <= 4'd12;
        end
        // restoring square root, one result bit per cycle
        if (cmd.sqrt_step) begin
            if (22'(rem_sh) >= trial) begin
                rem_reg <= 20'(rem_sh - trial);
                res_reg <= {res_reg[11:0], 1'b1};
            end else begin
                rem_reg <= 20'(rem_sh);
                res_reg <= {res_reg[11:0], 1'b0};
            end
            step_reg <= step_reg - 4'd1;
        end
        if (cmd.mul_step) begin
            prod_reg <= $signed({3'b0, res_reg}) * cos_reg;
            xl_reg   <= $signed({4'b0, cx_reg}) - $signed({9'b0, res_reg[12:8]});
            xr_reg   <= $signed({4'b0, cx_reg}) + $signed({9'b0, res_reg[12:8]});
        end
        if (cmd.finish) begin
            row_reg   <= 12'($signed({4'b0, cy_reg}) + 14'(dy));
            left_reg  <= left[11:0];
            right_reg <= right[11:0];
            empty_reg <= left > right;
            last_reg  <= off_reg == {r_reg, 1'b0};
        end
        if (cmd.row_next) off_reg <= off_reg + 6'd1;
    end

    assign stat.sqrt_done = (step_reg == 4'd0);
    assign stat.last_row  = last_reg;
    assign m_row_y        = row_reg;
    assign m_span_left    = left_reg;
    assign m_span_right   = right_reg;
    assign m_span_empty   = empty_reg;
    assign m_last_row     = last_reg;

    `include "moon_phase_disc_spans_unit_macros.svh"
    `MPD_ASSERT_IMPL(a_off_range, aclk, aresetn, cmd.finish, off_reg <= {r_reg, 1'b0})
    `MPD_ASSERT_IMPL(a_r_sat, aclk, aresetn, cmd.mul_step, res_reg[12:8] <= r_reg)
    `MPD_ASSERT_NEXT(a_step, aclk, aresetn, cmd.row_start, step_reg == 4'd12)

endmodule
